// File: hdl/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared types and constants for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package v3n_pkg;

   localparam int WORD_W     = 32;
   localparam int LIMIT_W    = 16;
   localparam int SUM_W      = 2 * WORD_W;
   localparam int SQRT_STEPS = WORD_W;
   localparam int LANES      = 3;

   typedef logic [WORD_W-1:0]             word_type;
   typedef logic [SUM_W-1:0]              sum_type;
   typedef logic [LANES-1:0][WORD_W-1:0]  mag3_type;

   // Control that rides along with each item through the cell rows
   typedef struct packed {
      logic             valid;
      logic [LANES-1:0] neg;
      logic             is_zero;
   } v3n_ctl_type;

endpackage

// File: hdl/v3n_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v3n_sqrt_cell
// One step of the bit-by-bit integer square root; yields one root bit.
// ----------------------------------------------------------------------------
module v3n_sqrt_cell import v3n_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  v3n_ctl_type ctl_in,
   input  sum_type     rem_in,
   input  sum_type     root_in,
   input  mag3_type    mag_in,
   output v3n_ctl_type ctl_out,
   output sum_type     rem_out,
   output sum_type     root_out,
   output mag3_type    mag_out
);

   localparam int BIT_POS = SUM_W - 2 - 2 * STEP;

   v3n_ctl_type ctl_ff;
   sum_type     rem_ff, rem_in_d;
   sum_type     root_ff, root_in_d;
   mag3_type    mag_ff;
   sum_type     trial;

   always_comb begin
      trial = root_in + (SUM_W'(1) << BIT_POS);
      if (rem_in >= trial) begin
         rem_in_d  = rem_in - trial;
         root_in_d = (root_in >> 1) + (SUM_W'(1) << BIT_POS);
      end else begin
         rem_in_d  = rem_in;
         root_in_d = root_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in_d;
         root_ff <= root_in_d;
         mag_ff  <= mag_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign mag_out  = mag_ff;

endmodule

// File: hdl/v3n_div_cell.sv
// ----------------------------------------------------------------------------
// v3n_div_cell
// One restoring-division step for three lanes; yields one quotient bit each.
// ----------------------------------------------------------------------------
module v3n_div_cell import v3n_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int SHIFT     = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  v3n_ctl_type                          ctl_in,
   input  word_type                             len_in,
   input  mag3_type                             mag_in,
   input  logic [LANES-1:0][WORD_W+FRAC_BITS-1:0] rem_in,
   input  logic [LANES-1:0][FRAC_BITS:0]        quo_in,
   output v3n_ctl_type                          ctl_out,
   output word_type                             len_out,
   output mag3_type                             mag_out,
   output logic [LANES-1:0][WORD_W+FRAC_BITS-1:0] rem_out,
   output logic [LANES-1:0][FRAC_BITS:0]        quo_out
);

   localparam int REM_W = WORD_W + FRAC_BITS;

   v3n_ctl_type                     ctl_ff;
   word_type                        len_ff;
   mag3_type                        mag_ff;
   logic [LANES-1:0][REM_W-1:0]     rem_ff, rem_in_d;
   logic [LANES-1:0][FRAC_BITS:0]   quo_ff, quo_in_d;
   logic [REM_W:0]                  divisor;

   always_comb begin
      divisor = (REM_W + 1)'(len_in) << SHIFT;
      for (int i = 0; i < LANES; i++) begin
         if ({1'b0, rem_in[i]} >= divisor) begin
            rem_in_d[i] = rem_in[i] - divisor[REM_W-1:0];
            quo_in_d[i] = {quo_in[i][FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_in_d[i] = rem_in[i];
            quo_in_d[i] = {quo_in[i][FRAC_BITS-1:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         len_ff <= len_in;
         mag_ff <= mag_in;
         rem_ff <= rem_in_d;
         quo_ff <= quo_in_d;
      end
   end

   assign ctl_out = ctl_ff;
   assign len_out = len_ff;
   assign mag_out = mag_ff;
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

// File: hdl/vector3_normalize.sv
// Path: stages A, B and C, the cell rows, then the output register.
// Throughput: one vector per cycle unless stalled; a row of 32 square-root
// cells and a row of FRAC_BITS+1 division cells each retire one bit per item
// per cycle. A stalled result holds the whole pipeline in place.
// Reset: synchronous, active high; clears valid bits and zero_limit.
// ----------------------------------------------------------------------------
// vector3_normalize
// Fixed-point 3D vector normalization: length by integer square root,
// components divided by the length, near-zero vectors passed through.
// ----------------------------------------------------------------------------
module vector3_normalize import v3n_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_norm_x,
   output logic signed [31:0] rsp_norm_y,
   output logic signed [31:0] rsp_norm_z,
   output logic [31:0]        rsp_vec_length,
   output logic               rsp_is_zero
);

   localparam int REM_W     = WORD_W + FRAC_BITS;
   localparam int DIV_STEPS = FRAC_BITS + 1;

   // Global advance: every stage moves unless a finished result is stalled
   logic enable;

   logic [LIMIT_W-1:0] zero_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_limit_ff <= '0;
      end else if (csr_wr_en) begin
         zero_limit_ff <= csr_wr_data;
      end
   end

   // Stage A: magnitudes and signs of the raw components
   v3n_ctl_type ctl_a_ff, ctl_a_in;
   mag3_type    mag_a_ff, mag_a_in;
   word_type    raw [LANES];

   assign raw[0] = req_vec_x;
   assign raw[1] = req_vec_y;
   assign raw[2] = req_vec_z;

   always_comb begin
      ctl_a_in         = '0;
      ctl_a_in.valid   = req_valid;
      for (int i = 0; i < LANES; i++) begin
         ctl_a_in.neg[i] = raw[i][WORD_W-1];
         mag_a_in[i]     = raw[i][WORD_W-1] ? (~raw[i] + WORD_W'(1)) : raw[i];
      end
   end

   // Stage B: squares, one multiplier per lane
   v3n_ctl_type                 ctl_b_ff;
   mag3_type                    mag_b_ff;
   logic [LANES-1:0][SUM_W-1:0] sq_b_ff;

   // Stage C: sum of squares
   v3n_ctl_type ctl_c_ff;
   mag3_type    mag_c_ff;
   sum_type     sum_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else if (enable) begin
         ctl_a_ff <= ctl_a_in;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_a_ff;
         for (int i = 0; i < LANES; i++) begin
            sq_b_ff[i] <= SUM_W'(mag_a_ff[i]) * SUM_W'(mag_a_ff[i]);
         end
         mag_c_ff <= mag_b_ff;
         sum_c_ff <= sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
      end
   end

   // Square-root row: one cell per root bit
   v3n_ctl_type sq_ctl  [SQRT_STEPS+1];
   sum_type     sq_rem  [SQRT_STEPS+1];
   sum_type     sq_root [SQRT_STEPS+1];
   mag3_type    sq_mag  [SQRT_STEPS+1];

   assign sq_ctl[0]  = ctl_c_ff;
   assign sq_rem[0]  = sum_c_ff;
   assign sq_root[0] = '0;
   assign sq_mag[0]  = mag_c_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      v3n_sqrt_cell #(.STEP(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .ctl_in   (sq_ctl[g]),
         .rem_in   (sq_rem[g]),
         .root_in  (sq_root[g]),
         .mag_in   (sq_mag[g]),
         .ctl_out  (sq_ctl[g+1]),
         .rem_out  (sq_rem[g+1]),
         .root_out (sq_root[g+1]),
         .mag_out  (sq_mag[g+1])
      );
   end

   // Division row: one cell per quotient bit, most significant first.
   // The length is never below any component magnitude, so the quotient
   // fits in FRAC_BITS+1 bits.
   v3n_ctl_type                   dv_ctl [DIV_STEPS+1];
   word_type                      dv_len [DIV_STEPS+1];
   mag3_type                      dv_mag [DIV_STEPS+1];
   logic [LANES-1:0][REM_W-1:0]   dv_rem [DIV_STEPS+1];
   logic [LANES-1:0][FRAC_BITS:0] dv_quo [DIV_STEPS+1];
   word_type                      root_len;

   assign root_len = sq_root[SQRT_STEPS][WORD_W-1:0];

   // Decide the zero case here, once the length is known
   assign dv_ctl[0] = '{valid:   sq_ctl[SQRT_STEPS].valid,
                        neg:     sq_ctl[SQRT_STEPS].neg,
                        is_zero: root_len <= WORD_W'(zero_limit_ff)};
   assign dv_len[0] = root_len;
   assign dv_mag[0] = sq_mag[SQRT_STEPS];
   assign dv_quo[0] = '0;

   for (genvar g = 0; g < LANES; g++) begin : g_rem0
      assign dv_rem[0][g] = REM_W'(sq_mag[SQRT_STEPS][g]) << FRAC_BITS;
   end

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      v3n_div_cell #(.FRAC_BITS(FRAC_BITS), .SHIFT(FRAC_BITS - g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .ctl_in  (dv_ctl[g]),
         .len_in  (dv_len[g]),
         .mag_in  (dv_mag[g]),
         .rem_in  (dv_rem[g]),
         .quo_in  (dv_quo[g]),
         .ctl_out (dv_ctl[g+1]),
         .len_out (dv_len[g+1]),
         .mag_out (dv_mag[g+1]),
         .rem_out (dv_rem[g+1]),
         .quo_out (dv_quo[g+1])
      );
   end

   // Output register: apply signs, or rebuild the raw input for a zero vector
   logic                   rsp_valid_ff;
   logic [LANES-1:0][31:0] norm_ff, norm_in;
   word_type               length_ff;
   logic                   is_zero_ff;
   v3n_ctl_type            fin_ctl;
   word_type               q_ext, m_val;

   assign fin_ctl = dv_ctl[DIV_STEPS];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         q_ext = WORD_W'(dv_quo[DIV_STEPS][i]);
         m_val = dv_mag[DIV_STEPS][i];
         if (fin_ctl.is_zero) begin
            norm_in[i] = fin_ctl.neg[i] ? (~m_val + WORD_W'(1)) : m_val;
         end else begin
            norm_in[i] = fin_ctl.neg[i] ? (~q_ext + WORD_W'(1)) : q_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= fin_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         norm_ff    <= norm_in;
         length_ff  <= dv_len[DIV_STEPS];
         is_zero_ff <= fin_ctl.is_zero;
      end
   end

   // Hold off input during reset so no transfer is dropped
   assign enable         = !(rsp_valid_ff && rsp_stall);
   assign req_stall      = !enable || reset;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_norm_x     = norm_ff[0];
   assign rsp_norm_y     = norm_ff[1];
   assign rsp_norm_z     = norm_ff[2];
   assign rsp_vec_length = length_ff;
   assign rsp_is_zero    = is_zero_ff;

`ifndef SYNTHESIS
   // A normalized result always has a length above the zero limit
   a_len_above_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_zero |-> rsp_vec_length > WORD_W'(zero_limit_ff))
      else $error("normalized result with length at or below zero limit");

   // A zero length is always flagged
   a_zero_len_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vec_length == '0 |-> rsp_is_zero)
      else $error("zero length not flagged");

   // The normalized x component stays within one unit
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_zero |->
         (rsp_norm_x <= (32'sd1 <<< FRAC_BITS)) && (rsp_norm_x >= -(32'sd1 <<< FRAC_BITS)))
      else $error("normalized x outside unit range");
`endif

endmodule

// File: tb/tb_vector3_normalize.sv
// ----------------------------------------------------------------------------
// tb_vector3_normalize
// Self-checking bench for the 3D vector normalizer. Directed corner vectors,
// then random vectors under several zero limits and idle patterns; every
// result is compared field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_vector3_normalize import v3n_pkg::*;;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 37;

   // Expected result of one vector
   typedef struct {
      logic [31:0] nx, ny, nz, len;
      logic        zflag;
   } norm_result_type;

   // Predicts results from accepted vectors and checks arriving results
   class norm_scoreboard;
      norm_result_type pending[$];
      logic [15:0]  limit;
      int           errors;

      function logic [63:0] isqrt(logic [63:0] v);
         logic [63:0] root, bit_w;
         root = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > v) bit_w = bit_w >> 2;
         while (bit_w != 0) begin
            if (v >= root + bit_w) begin
               v = v - (root + bit_w);
               root = (root >> 1) + bit_w;
            end else begin
               root = root >> 1;
            end
            bit_w = bit_w >> 2;
         end
         return root;
      endfunction

      function logic [63:0] mag_of(logic [31:0] c);
         return c[31] ? (64'd1 << 32) - {32'd0, c} : {32'd0, c};
      endfunction

      function logic [31:0] divide(logic [31:0] c, logic [63:0] len);
         logic [63:0] q;
         q = (mag_of(c) << FRAC) / len;
         if (c[31]) q = 64'd0 - q;
         return q[31:0];
      endfunction

      function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
         norm_result_type r;
         logic [63:0] sum, len;
         sum = mag_of(x) * mag_of(x) + mag_of(y) * mag_of(y) + mag_of(z) * mag_of(z);
         len = isqrt(sum);
         r.len = len[31:0];
         if (len <= {48'd0, limit}) begin
            r.nx = x; r.ny = y; r.nz = z; r.zflag = 1'b1;
         end else begin
            r.nx = divide(x, len); r.ny = divide(y, len); r.nz = divide(z, len);
            r.zflag = 1'b0;
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [31:0] len, logic zflag);
         norm_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result len=%h", $time, len);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (x !== e.nx) begin
            $display("%0t: norm_x expected %h actual %h", $time, e.nx, x); errors++;
         end
         if (y !== e.ny) begin
            $display("%0t: norm_y expected %h actual %h", $time, e.ny, y); errors++;
         end
         if (z !== e.nz) begin
            $display("%0t: norm_z expected %h actual %h", $time, e.nz, z); errors++;
         end
         if (len !== e.len) begin
            $display("%0t: vec_length expected %h actual %h", $time, e.len, len); errors++;
         end
         if (zflag !== e.zflag) begin
            $display("%0t: is_zero expected %b actual %b", $time, e.zflag, zflag); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [31:0] rsp_vec_length;
   logic rsp_is_zero;

   // Idle percentages for each side, and the long hold-off request
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_request = 0;

   norm_scoreboard sb = new();

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   vector3_normalize #(.FRAC_BITS(FRAC)) dut (.*);

   // Check every result transfer on the edge it happens
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_vec_length, rsp_is_zero);
   end

   // Receiver stall: random idling, plus one long hold-off when asked
   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !held) begin
            hold = 300;
            held = 1;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(5))
         0: return $urandom_range(255) - 128;
         1: return $urandom_range(65535) - 32768;
         2: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(16);
         default: return $urandom;
      endcase
   endfunction

   // Offer one vector and hold it until it transfers; gaps come first
   task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      do @(posedge clock); while (req_stall);
      sb.note_vector(x, y, z);
   endtask

   // Drop valid and wait for every expected result, then let the pipe drain
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_limit(logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.limit = v;
   endtask

   initial begin
      logic [15:0] limits[5];
      logic [31:0] a;
      limits = '{16'd0, 16'hFFFF, 16'd1, 16'd300, 16'h8000};
      sb.limit = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners at reset limit 0
      send_vector(0, 0, 0);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h8000_0000, 0, 0);
      send_vector(0, 32'h7FFF_FFFF, 0);
      send_vector(0, 0, 32'hFFFF_FFFF);
      send_vector(32'h0001_0000, 0, 0);
      send_vector(0, 32'hFFFF_0000, 0);
      send_vector(3, 4, 0);
      send_vector(32'hFFFF_FFFD, 0, 32'hFFFF_FFFC);
      send_vector(1, 1, 1);
      send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678);
      drain();
      // Zero-limit boundary: length exactly at and just above the limit
      write_limit(16'd5);
      send_vector(3, 4, 0);
      send_vector(0, 6, 0);
      send_vector(32'hFFFF_FFFB, 0, 0);
      drain();
      write_limit(16'hFFFF);
      send_vector(32'h0000_FFFF, 0, 0);
      send_vector(0, 0, 32'hFFFF_0000);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         write_limit(limits[phase]);
         send_idle = (phase < 2) ? (phase == 0 ? 27 : 53) : 0;
         recv_idle = (phase < 2) ? (phase == 0 ? 53 : 27) : 0;
         if (phase == 2) hold_request = 1'b1;
         for (int i = 0; i < 360; i++) begin
            // Small vectors sometimes sit near the limit
            if ($urandom_range(3) == 0) begin
               a = $urandom_range(2 * limits[phase] + 2);
               send_vector($urandom_range(1) ? a : -a, $urandom_range(3), 0);
            end else begin
               send_vector(rand_comp(), rand_comp(), rand_comp());
            end
         end
         drain();
      end

      if (sb.errors == 0)
         $display("tb_vector3_normalize OK");
      else
         $display("tb_vector3_normalize NOT OK");
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("tb_vector3_normalize NOT OK");
      $finish;
   end

endmodule
